>>> design/deq_pkg.sv
`default_nettype none

package deq_pkg;

  localparam int unsigned DEPTH_DEF = 16;

  // action codes
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_REAR  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_REAR   = 3'd3;
  localparam logic [2:0] ACT_RM_MIN     = 3'd4;
  localparam logic [2:0] ACT_READ       = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_RANGE    = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PUSH_FRONT,
    OP_PUSH_REAR,
    OP_POP_FRONT,
    OP_POP_REAR,
    OP_READ,
    OP_TAKE_FRONT,
    OP_TAKE_REAR,
    OP_TAKE_READ,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_PACK_INIT,
    OP_PACK,
    OP_PACK_END,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       st_we;
    logic [1:0] st;
  } cmd_t;

  typedef struct packed {
    logic [2:0] act;
    logic       full;
    logic       empty;
    logic       one_left;
    logic       pos_oob;
    logic       walk_done;
  } sts_t;

endpackage

`default_nettype wire

>>> design/deq_dp.sv
`default_nettype none

module deq_dp #(
  parameter int unsigned DEPTH = deq_pkg::DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire deq_pkg::cmd_t       cmd,
  output deq_pkg::sts_t            sts,
  input  wire logic [2:0]          in_action,
  input  wire logic signed [31:0]  in_value,
  input  wire logic [3:0]          in_position,
  output logic                     out_strobe,
  output logic [1:0]               out_status,
  output logic signed [31:0]       out_read_value,
  output logic signed [31:0]       out_front_value,
  output logic signed [31:0]       out_rear_value,
  output logic [4:0]               out_entry_count,
  output logic                     out_is_empty
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);

  function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
    wrap = (s >= DEPTH_S) ? AW'(s - DEPTH_S) : AW'(s);
  endfunction

  logic [31:0]   mem_r [DEPTH];
  logic [31:0]   rd_data_r;

  logic [2:0]    act_r,   act_nxt;
  logic [31:0]   val_r,   val_nxt;
  logic [3:0]    pos_r,   pos_nxt;
  logic [AW-1:0] head_r,  head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r,   idx_nxt;
  logic [CW-1:0] wcnt_r,  wcnt_nxt;
  logic          pend_r,  pend_nxt;
  logic [31:0]   front_r, front_nxt;
  logic [31:0]   rear_r,  rear_nxt;
  logic [31:0]   min_r,   min_nxt;
  logic [31:0]   rdval_r, rdval_nxt;
  logic [1:0]    st_r,    st_nxt;

  logic          strobe_r,  strobe_nxt;
  logic [1:0]    o_st_r,    o_st_nxt;
  logic [31:0]   o_rd_r,    o_rd_nxt;
  logic [31:0]   o_front_r, o_front_nxt;
  logic [31:0]   o_rear_r,  o_rear_nxt;
  logic [4:0]    o_cnt_r,   o_cnt_nxt;
  logic          o_emp_r,   o_emp_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] head_m1;
  logic          is_empty;
  logic          walk_more;

  assign head_m1   = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
  assign is_empty  = (count_r == '0);
  assign walk_more = (idx_r < count_r);

  assign sts.act       = act_r;
  assign sts.full      = (count_r == CW'(DEPTH));
  assign sts.empty     = is_empty;
  assign sts.one_left  = (count_r == CW'(1));
  assign sts.pos_oob   = (32'(pos_r) >= 32'(count_r));
  assign sts.walk_done = (idx_r == count_r) && !pend_r;

  always_comb begin
    act_nxt     = act_r;
    val_nxt     = val_r;
    pos_nxt     = pos_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    wcnt_nxt    = wcnt_r;
    pend_nxt    = pend_r;
    front_nxt   = front_r;
    rear_nxt    = rear_r;
    min_nxt     = min_r;
    rdval_nxt   = rdval_r;
    st_nxt      = st_r;
    strobe_nxt  = 1'b0;
    o_st_nxt    = o_st_r;
    o_rd_nxt    = o_rd_r;
    o_front_nxt = o_front_r;
    o_rear_nxt  = o_rear_r;
    o_cnt_nxt   = o_cnt_r;
    o_emp_nxt   = o_emp_r;
    wr_en       = 1'b0;
    wr_addr     = head_r;
    wr_data     = val_r;
    rd_addr     = wrap(SW'(head_r) + SW'(idx_r));

    unique case (cmd.op)
      deq_pkg::OP_NONE: begin
      end
      deq_pkg::OP_LOAD: begin
        act_nxt   = in_action;
        val_nxt   = in_value;
        pos_nxt   = in_position;
        st_nxt    = deq_pkg::ST_OK;
        rdval_nxt = '0;
      end
      deq_pkg::OP_PUSH_FRONT: begin
        wr_en     = 1'b1;
        wr_addr   = head_m1;
        head_nxt  = head_m1;
        count_nxt = count_r + CW'(1);
        front_nxt = val_r;
        if (is_empty) begin
          rear_nxt = val_r;
        end
      end
      deq_pkg::OP_PUSH_REAR: begin
        wr_en     = 1'b1;
        wr_addr   = wrap(SW'(head_r) + SW'(count_r));
        count_nxt = count_r + CW'(1);
        rear_nxt  = val_r;
        if (is_empty) begin
          front_nxt = val_r;
        end
      end
      deq_pkg::OP_POP_FRONT: begin
        rd_addr   = wrap(SW'(head_r) + SW'(1));
        head_nxt  = wrap(SW'(head_r) + SW'(1));
        count_nxt = count_r - CW'(1);
      end
      deq_pkg::OP_POP_REAR: begin
        rd_addr   = wrap(SW'(head_r) + SW'(count_r) - SW'(2));
        count_nxt = count_r - CW'(1);
      end
      deq_pkg::OP_READ: begin
        rd_addr = wrap(SW'(head_r) + SW'(pos_r));
      end
      deq_pkg::OP_TAKE_FRONT: begin
        front_nxt = rd_data_r;
      end
      deq_pkg::OP_TAKE_REAR: begin
        rear_nxt = rd_data_r;
      end
      deq_pkg::OP_TAKE_READ: begin
        rdval_nxt = rd_data_r;
      end
      deq_pkg::OP_SCAN_INIT: begin
        min_nxt  = front_r;
        idx_nxt  = CW'(1);
        pend_nxt = 1'b0;
      end
      deq_pkg::OP_SCAN: begin
        pend_nxt = walk_more;
        if (walk_more) begin
          idx_nxt = idx_r + CW'(1);
        end
        if (pend_r && ($signed(rd_data_r) < $signed(min_r))) begin
          min_nxt = rd_data_r;
        end
      end
      deq_pkg::OP_PACK_INIT: begin
        idx_nxt  = '0;
        wcnt_nxt = '0;
        pend_nxt = 1'b0;
      end
      deq_pkg::OP_PACK: begin
        pend_nxt = walk_more;
        if (walk_more) begin
          idx_nxt = idx_r + CW'(1);
        end
        // survivors move down behind the read pointer
        if (pend_r && (rd_data_r != min_r)) begin
          wr_en    = 1'b1;
          wr_addr  = wrap(SW'(head_r) + SW'(wcnt_r));
          wr_data  = rd_data_r;
          wcnt_nxt = wcnt_r + CW'(1);
          rear_nxt = rd_data_r;
          if (wcnt_r == '0) begin
            front_nxt = rd_data_r;
          end
        end
      end
      deq_pkg::OP_PACK_END: begin
        count_nxt = wcnt_r;
      end
      deq_pkg::OP_EMIT: begin
        strobe_nxt  = 1'b1;
        o_st_nxt    = st_r;
        o_rd_nxt    = rdval_r;
        o_front_nxt = is_empty ? '0 : front_r;
        o_rear_nxt  = is_empty ? '0 : rear_r;
        o_cnt_nxt   = 5'(count_r);
        o_emp_nxt   = is_empty;
      end
      default: begin
      end
    endcase

    if (cmd.st_we) begin
      st_nxt = cmd.st;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      count_r  <= '0;
      pend_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      pend_r   <= pend_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    val_r     <= val_nxt;
    pos_r     <= pos_nxt;
    idx_r     <= idx_nxt;
    wcnt_r    <= wcnt_nxt;
    front_r   <= front_nxt;
    rear_r    <= rear_nxt;
    min_r     <= min_nxt;
    rdval_r   <= rdval_nxt;
    st_r      <= st_nxt;
    o_st_r    <= o_st_nxt;
    o_rd_r    <= o_rd_nxt;
    o_front_r <= o_front_nxt;
    o_rear_r  <= o_rear_nxt;
    o_cnt_r   <= o_cnt_nxt;
    o_emp_r   <= o_emp_nxt;
  end

  assign out_strobe      = strobe_r;
  assign out_status      = o_st_r;
  assign out_read_value  = o_rd_r;
  assign out_front_value = o_front_r;
  assign out_rear_value  = o_rear_r;
  assign out_entry_count = o_cnt_r;
  assign out_is_empty    = o_emp_r;

endmodule

`default_nettype wire

>>> design/deq_ctrl.sv
`default_nettype none

module deq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire deq_pkg::sts_t sts,
  output logic               busy,
  output deq_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_GET_FRONT,
    S_GET_REAR,
    S_GET_READ,
    S_SCAN,
    S_PACK,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '{op: deq_pkg::OP_NONE, st_we: 1'b0, st: deq_pkg::ST_OK};

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = deq_pkg::OP_LOAD;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_FIN;
        unique case (sts.act) inside
          deq_pkg::ACT_PUSH_FRONT, deq_pkg::ACT_PUSH_REAR: begin
            if (sts.full) begin
              cmd.st_we = 1'b1;
              cmd.st    = deq_pkg::ST_OVERFLOW;
            end else begin
              cmd.op = (sts.act == deq_pkg::ACT_PUSH_FRONT) ? deq_pkg::OP_PUSH_FRONT
                                                           : deq_pkg::OP_PUSH_REAR;
            end
          end
          deq_pkg::ACT_POP_FRONT: begin
            if (sts.empty) begin
              cmd.st_we = 1'b1;
              cmd.st    = deq_pkg::ST_EMPTY;
            end else begin
              cmd.op = deq_pkg::OP_POP_FRONT;
              if (!sts.one_left) begin
                state_nxt = S_GET_FRONT;
              end
            end
          end
          deq_pkg::ACT_POP_REAR: begin
            if (sts.empty) begin
              cmd.st_we = 1'b1;
              cmd.st    = deq_pkg::ST_EMPTY;
            end else begin
              cmd.op = deq_pkg::OP_POP_REAR;
              if (!sts.one_left) begin
                state_nxt = S_GET_REAR;
              end
            end
          end
          deq_pkg::ACT_RM_MIN: begin
            if (sts.empty) begin
              cmd.st_we = 1'b1;
              cmd.st    = deq_pkg::ST_EMPTY;
            end else begin
              cmd.op    = deq_pkg::OP_SCAN_INIT;
              state_nxt = S_SCAN;
            end
          end
          deq_pkg::ACT_READ: begin
            if (sts.pos_oob) begin
              cmd.st_we = 1'b1;
              cmd.st    = deq_pkg::ST_RANGE;
            end else begin
              cmd.op    = deq_pkg::OP_READ;
              state_nxt = S_GET_READ;
            end
          end
          default: begin
          end
        endcase
      end
      S_GET_FRONT: begin
        cmd.op    = deq_pkg::OP_TAKE_FRONT;
        state_nxt = S_FIN;
      end
      S_GET_REAR: begin
        cmd.op    = deq_pkg::OP_TAKE_REAR;
        state_nxt = S_FIN;
      end
      S_GET_READ: begin
        cmd.op    = deq_pkg::OP_TAKE_READ;
        state_nxt = S_FIN;
      end
      S_SCAN: begin
        if (sts.walk_done) begin
          cmd.op    = deq_pkg::OP_PACK_INIT;
          state_nxt = S_PACK;
        end else begin
          cmd.op = deq_pkg::OP_SCAN;
        end
      end
      S_PACK: begin
        if (sts.walk_done) begin
          cmd.op    = deq_pkg::OP_PACK_END;
          state_nxt = S_FIN;
        end else begin
          cmd.op = deq_pkg::OP_PACK;
        end
      end
      S_FIN: begin
        cmd.op    = deq_pkg::OP_EMIT;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

>>> design/deque_with_delete_all_min.sv
`default_nettype none

// channel   ports                                   handshake
// request   in_action, in_value, in_position        start high while busy low
// result    out_status, out_read_value,             out_strobe, one cycle,
//           out_front_value, out_rear_value,         cannot be held off
//           out_entry_count, out_is_empty
//
// push, or any request that fails or does nothing: load, execute and finish
// states, then the registered strobe; a new request can be taken while out_strobe is high
// pop that leaves entries behind, read: an extra take state for the registered store read
// remove all minimum: one store read per cycle in a minimum scan then a
// compaction pass over the held entries
// synchronous reset clears the pointers and the controller; no clearing pass
// busy stays high from the request until its result strobe

module deque_with_delete_all_min #(
  parameter int unsigned DEPTH = deq_pkg::DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         in_action,
  input  wire logic signed [31:0] in_value,
  input  wire logic [3:0]         in_position,
  output logic                    out_strobe,
  output logic [1:0]              out_status,
  output logic signed [31:0]      out_read_value,
  output logic signed [31:0]      out_front_value,
  output logic signed [31:0]      out_rear_value,
  output logic [4:0]              out_entry_count,
  output logic                    out_is_empty
);

  deq_pkg::cmd_t cmd;
  deq_pkg::sts_t sts;

  deq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  deq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_action       (in_action),
    .in_value        (in_value),
    .in_position     (in_position),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_front_value (out_front_value),
    .out_rear_value  (out_rear_value),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty)
  );

endmodule

`default_nettype wire

>>> design/deq_chk.sv
`default_nettype none

module deq_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               out_strobe,
  input wire logic [1:0]         out_status,
  input wire logic signed [31:0] out_read_value,
  input wire logic signed [31:0] out_front_value,
  input wire logic signed [31:0] out_rear_value,
  input wire logic [4:0]         out_entry_count,
  input wire logic               out_is_empty
);

  a_taken_goes_busy : assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request taken but busy not raised");

  a_no_instant_result : assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> !out_strobe)
    else $error("result strobe right after request");

  a_result_frees : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("busy still high with result strobe");

  a_empty_zeros : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_is_empty |->
      out_entry_count == 5'd0 && out_front_value == 32'sd0 && out_rear_value == 32'sd0)
    else $error("empty result with nonzero count or ends");

  a_read_only_ok : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status != deq_pkg::ST_OK |-> out_read_value == 32'sd0)
    else $error("read value on failed request");

endmodule

bind deque_with_delete_all_min deq_chk u_deq_chk (.*);

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int DEPTH = deq_pkg::DEPTH_DEF;
  localparam int RANDOM_REQS = 850;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_CYCLES = 60;
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;

  typedef struct {
    logic [2:0]         act;
    logic signed [31:0] val;
    logic [3:0]         pos;
    bit                 drain;
    int unsigned        gap;
  } deque_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic signed [31:0] front_value;
    logic signed [31:0] rear_value;
    logic [4:0]         entry_count;
    logic               is_empty;
  } deque_result_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [2:0]          in_action;
  logic signed [31:0]  in_value;
  logic [3:0]          in_position;
  logic                out_strobe;
  logic [1:0]          out_status;
  logic signed [31:0]  out_read_value;
  logic signed [31:0]  out_front_value;
  logic signed [31:0]  out_rear_value;
  logic [4:0]          out_entry_count;
  logic                out_is_empty;

  deque_req_t    pending_reqs[$];
  deque_result_t expected_results[$];
  deque_req_t    next_req;
  int unsigned   reqs_offered;
  int unsigned   reqs_taken;
  int unsigned   reqs_total;
  int unsigned   gap_left;
  int unsigned   mismatch_count;
  int unsigned   idle_cycles;
  bit            drain_next;
  bit            no_idle;

  logic signed [31:0] shadow_store[DEPTH];
  logic [3:0]         shadow_head;
  logic [4:0]         shadow_count;

  deque_with_delete_all_min u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_value        (in_value),
    .in_position     (in_position),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_front_value (out_front_value),
    .out_rear_value  (out_rear_value),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic deque_result_t apply_request(logic [2:0] act, logic signed [31:0] val,
                                                  logic [3:0] pos);
    deque_result_t      r;
    logic signed [31:0] lowest;
    logic [4:0]         kept;
    logic [3:0]         slot;
    logic [3:0]         dst;
    r = '0;
    r.status = deq_pkg::ST_OK;
    case (act)
      deq_pkg::ACT_PUSH_FRONT: begin
        if (shadow_count == DEPTH) begin
          r.status = deq_pkg::ST_OVERFLOW;
        end else begin
          shadow_head = shadow_head - 4'd1;
          shadow_store[shadow_head] = val;
          shadow_count = shadow_count + 5'd1;
        end
      end
      deq_pkg::ACT_PUSH_REAR: begin
        if (shadow_count == DEPTH) begin
          r.status = deq_pkg::ST_OVERFLOW;
        end else begin
          slot = shadow_head + shadow_count[3:0];
          shadow_store[slot] = val;
          shadow_count = shadow_count + 5'd1;
        end
      end
      deq_pkg::ACT_POP_FRONT: begin
        if (shadow_count == 0) begin
          r.status = deq_pkg::ST_EMPTY;
        end else begin
          shadow_head = shadow_head + 4'd1;
          shadow_count = shadow_count - 5'd1;
        end
      end
      deq_pkg::ACT_POP_REAR: begin
        if (shadow_count == 0) r.status = deq_pkg::ST_EMPTY;
        else shadow_count = shadow_count - 5'd1;
      end
      deq_pkg::ACT_RM_MIN: begin
        if (shadow_count == 0) begin
          r.status = deq_pkg::ST_EMPTY;
        end else begin
          lowest = shadow_store[shadow_head];
          for (int i = 1; i < shadow_count; i++) begin
            slot = shadow_head + 4'(i);
            if (shadow_store[slot] < lowest) lowest = shadow_store[slot];
          end
          kept = '0;
          for (int i = 0; i < shadow_count; i++) begin
            slot = shadow_head + 4'(i);
            if (shadow_store[slot] != lowest) begin
              dst = shadow_head + kept[3:0];
              shadow_store[dst] = shadow_store[slot];
              kept = kept + 5'd1;
            end
          end
          shadow_count = kept;
        end
      end
      deq_pkg::ACT_READ: begin
        if ({1'b0, pos} >= shadow_count) begin
          r.status = deq_pkg::ST_RANGE;
        end else begin
          slot = shadow_head + pos;
          r.read_value = shadow_store[slot];
        end
      end
      default: ;
    endcase
    if (shadow_count != 0) begin
      slot = shadow_head + shadow_count[3:0] - 4'd1;
      r.front_value = shadow_store[shadow_head];
      r.rear_value = shadow_store[slot];
    end
    r.entry_count = shadow_count;
    r.is_empty = (shadow_count == 0);
    return r;
  endfunction

  function automatic logic signed [31:0] pick_value(bit narrow);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (narrow || roll < 40) return $signed(32'($urandom_range(0, 8))) - 32'sd4;
    if (roll < 50) begin
      case ($urandom_range(0, 3))
        0: return 32'h7fff_ffff;
        1: return 32'h8000_0000;
        2: return 32'h0;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [2:0] pick_action(int unsigned phase);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return roll[0] ? ACT_SPARE_7 : ACT_SPARE_6;
    case (phase)
      0: begin
        if (roll < 38) return deq_pkg::ACT_PUSH_FRONT;
        if (roll < 70) return deq_pkg::ACT_PUSH_REAR;
        if (roll < 82) return deq_pkg::ACT_READ;
        if (roll < 90) return deq_pkg::ACT_RM_MIN;
        return roll[0] ? deq_pkg::ACT_POP_FRONT : deq_pkg::ACT_POP_REAR;
      end
      1: begin
        if (roll < 35) return deq_pkg::ACT_POP_FRONT;
        if (roll < 62) return deq_pkg::ACT_POP_REAR;
        if (roll < 76) return deq_pkg::ACT_RM_MIN;
        if (roll < 90) return deq_pkg::ACT_READ;
        return deq_pkg::ACT_PUSH_REAR;
      end
      3: begin
        if (roll < 28) return deq_pkg::ACT_PUSH_FRONT;
        if (roll < 56) return deq_pkg::ACT_PUSH_REAR;
        if (roll < 80) return deq_pkg::ACT_RM_MIN;
        return deq_pkg::ACT_READ;
      end
      default: return 3'($urandom_range(0, 5));
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_req(logic [2:0] act, logic signed [31:0] val, logic [3:0] pos);
    deque_req_t r;
    r.act = act;
    r.val = val;
    r.pos = pos;
    r.drain = drain_next;
    r.gap = pick_gap();
    drain_next = 1'b0;
    pending_reqs.push_back(r);
    reqs_total++;
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (start && reqs_taken != reqs_offered) begin
        // request still waiting for the block
      end else if (gap_left != 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() == 0 ||
                   (pending_reqs[0].drain && expected_results.size() != 0)) begin
        start <= 1'b0;
      end else begin
        next_req = pending_reqs.pop_front();
        in_action <= next_req.act;
        in_value <= next_req.val;
        in_position <= next_req.pos;
        start <= 1'b1;
        reqs_offered <= reqs_offered + 1;
        gap_left <= next_req.gap;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    deque_result_t got;
    deque_result_t want;
    if (rst_n) begin
      if (start && !busy) begin
        reqs_taken <= reqs_taken + 1;
        expected_results.push_back(apply_request(in_action, in_value, in_position));
      end
      if (out_strobe) begin
        got = '{out_status, out_read_value, out_front_value, out_rear_value,
                out_entry_count, out_is_empty};
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: status=%0d read=%0d front=%0d rear=%0d",
                     got.status, $signed(got.read_value), $signed(got.front_value),
                     $signed(got.rear_value));
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch exp: status=%0d read=%0d front=%0d rear=%0d count=%0d empty=%0b",
                       want.status, $signed(want.read_value), $signed(want.front_value),
                       $signed(want.rear_value), want.entry_count, want.is_empty);
              $display("         got: status=%0d read=%0d front=%0d rear=%0d count=%0d empty=%0b",
                       got.status, $signed(got.read_value), $signed(got.front_value),
                       $signed(got.rear_value), got.entry_count, got.is_empty);
            end
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_strobe) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned phase;
    int unsigned run_len;
    int unsigned made;
    bit          narrow;
    logic [2:0]  act;
    rst_n = 1'b0;
    start = 1'b0;
    in_action = deq_pkg::ACT_PUSH_FRONT;
    in_value = '0;
    in_position = '0;
    reqs_offered = 0;
    reqs_taken = 0;
    reqs_total = 0;
    gap_left = 0;
    mismatch_count = 0;
    idle_cycles = 0;
    drain_next = 1'b0;
    no_idle = 1'b0;
    shadow_head = '0;
    shadow_count = '0;
    foreach (shadow_store[i]) shadow_store[i] = '0;

    // empty deque
    add_req(deq_pkg::ACT_POP_FRONT, 32'sd0, 4'd0);
    add_req(deq_pkg::ACT_POP_REAR, 32'sd0, 4'd0);
    add_req(deq_pkg::ACT_RM_MIN, 32'sd0, 4'd0);
    add_req(deq_pkg::ACT_READ, 32'sd0, 4'd0);
    add_req(ACT_SPARE_6, $urandom, 4'($urandom));
    add_req(ACT_SPARE_7, $urandom, 4'($urandom));
    // fill to full with extremes and a repeated minimum
    add_req(deq_pkg::ACT_PUSH_FRONT, 32'h7fff_ffff, 4'd0);
    add_req(deq_pkg::ACT_PUSH_REAR, 32'h8000_0000, 4'd0);
    add_req(deq_pkg::ACT_PUSH_FRONT, 32'h8000_0000, 4'd0);
    add_req(deq_pkg::ACT_PUSH_REAR, 32'hffff_ffff, 4'd0);
    add_req(deq_pkg::ACT_PUSH_REAR, 32'h0, 4'd0);
    for (int i = 0; i < 11; i++)
      add_req(i[0] ? deq_pkg::ACT_PUSH_FRONT : deq_pkg::ACT_PUSH_REAR,
              pick_value(1'b1), 4'd0);
    add_req(deq_pkg::ACT_PUSH_FRONT, 32'sd5, 4'd0);
    add_req(deq_pkg::ACT_PUSH_REAR, 32'sd5, 4'd0);
    add_req(deq_pkg::ACT_READ, 32'sd0, 4'd15);
    add_req(deq_pkg::ACT_READ, 32'sd0, 4'd0);
    add_req(deq_pkg::ACT_RM_MIN, 32'sd0, 4'd0);
    add_req(deq_pkg::ACT_READ, 32'sd0, 4'd15);
    add_req(deq_pkg::ACT_POP_FRONT, 32'sd0, 4'd0);
    add_req(deq_pkg::ACT_POP_REAR, 32'sd0, 4'd0);

    drain_next = 1'b1;
    made = 0;
    while (made < RANDOM_REQS) begin
      phase = $urandom_range(0, 3);
      run_len = $urandom_range(10, 40);
      narrow = ($urandom_range(0, 2) == 0) || phase == 3;
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 5) == 0) drain_next = 1'b1;
      for (int i = 0; i < run_len; i++) begin
        act = pick_action(phase);
        add_req(act, pick_value(narrow), 4'($urandom_range(0, 15)));
        made++;
      end
    end

    @(posedge clk);
    while (reqs_taken != reqs_total) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

endmodule

>>> files.f
design/deq_pkg.sv
design/deq_dp.sv
design/deq_ctrl.sv
design/deque_with_delete_all_min.sv
design/deq_chk.sv
dv/tb_top.sv
